// File: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define TFTPRX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge while reset is released.
`define TFTPRX_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: src/tftprx_pkg.sv
// Shared types and codes for the TFTP windowed read receiver.
// Depends on nothing; used by every module of the block.
package tftprx_pkg;

  // Event kinds of an input transaction.
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_PACKET = 2'd2;

  // Packet opcodes that the receiver acts on.
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] OP_OACK  = 16'd6;

  // What to send in reply.
  localparam logic [2:0] SK_NONE = 3'd0;
  localparam logic [2:0] SK_RRQ  = 3'd1;
  localparam logic [2:0] SK_ACK  = 3'd2;
  localparam logic [2:0] SK_TID  = 3'd3;
  localparam logic [2:0] SK_ILL  = 3'd4;

  // Transfer status.
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Header bytes ahead of the payload in a DATA packet.
  localparam logic [9:0] HDR_BYTES = 10'd4;

  // One input event.
  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  pkt_len;
    logic [15:0] opcode;
    logic [15:0] block_num;
    logic        sender_matches;
    logic        oack_valid;
    logic [6:0]  oack_window;
  } item_t;

  // One result.
  typedef struct packed {
    logic [2:0]  send_kind;
    logic [15:0] ack_block;
    logic        write_payload;
    logic [1:0]  status;
  } result_t;

endpackage

// File: src/tftprx_in_stage.sv
// Input register of the TFTP receiver: holds one event transaction.
// Depends on tftprx_pkg.
module tftprx_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tftprx_pkg::item_t   item_i,
  input  logic                take_i,
  output logic                valid_o,
  output tftprx_pkg::item_t   item_o
);
  import tftprx_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The register frees up in the same cycle that its item moves on.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  // Valid flag with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/tftprx_engine.sv
// Protocol engine of the TFTP receiver: transfer state and the combinational
// step that turns an event into a result. Depends on tftprx_pkg.
module tftprx_engine #(
  parameter int unsigned MAX_RETRIES = 5,
  parameter int unsigned BLOCK_BYTES = 512,
  parameter int unsigned MAX_WINDOW  = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  tftprx_pkg::item_t    item_i,
  output tftprx_pkg::result_t  result_o
);
  import tftprx_pkg::*;

  localparam logic [3:0]  MaxRetriesW = 4'(MAX_RETRIES);
  localparam logic [16:0] BlockBytesW = 17'(BLOCK_BYTES);
  localparam logic [6:0]  MaxWindowW  = 7'(MAX_WINDOW);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_RECV
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] exp_q, exp_d;
  logic [15:0] last_q, last_d;
  logic [6:0]  wcnt_q, wcnt_d;
  logic [3:0]  retry_q, retry_d;
  logic [6:0]  wlim_q, wlim_d;
  result_t     res;

  logic        len_ok;
  logic [9:0]  pay_len;
  logic        short_pay;
  logic [3:0]  retry_inc;
  logic [6:0]  wcnt_inc;
  logic [6:0]  win_clamp;

  // Small decodes shared by the step logic.
  assign len_ok    = item_i.pkt_len >= HDR_BYTES;
  assign pay_len   = item_i.pkt_len - HDR_BYTES;
  assign short_pay = {7'd0, pay_len} < BlockBytesW;
  assign retry_inc = retry_q + 4'd1;
  assign wcnt_inc  = wcnt_q + 7'd1;

  always_comb begin
    if (item_i.oack_window == 7'd0) begin
      win_clamp = 7'd1;
    end else if (item_i.oack_window > MaxWindowW) begin
      win_clamp = MaxWindowW;
    end else begin
      win_clamp = item_i.oack_window;
    end
  end

  // One event step: next state and result.
  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    last_d  = last_q;
    wcnt_d  = wcnt_q;
    retry_d = retry_q;
    wlim_d  = wlim_q;
    res     = '{send_kind: SK_NONE, ack_block: 16'd0, write_payload: 1'b0, status: ST_RUN};

    unique case (item_i.kind)
      KIND_START: begin
        phase_d       = PH_WAIT;
        exp_d         = 16'd0;
        last_d        = 16'd0;
        wcnt_d        = 7'd0;
        retry_d       = 4'd0;
        wlim_d        = 7'd1;
        res.send_kind = SK_RRQ;
      end
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (retry_inc >= MaxRetriesW) begin
            phase_d    = PH_IDLE;
            wcnt_d     = 7'd0;
            retry_d    = 4'd0;
            res.status = ST_FAIL;
          end else if (phase_q == PH_WAIT) begin
            retry_d       = retry_inc;
            res.send_kind = SK_RRQ;
          end else begin
            retry_d       = retry_inc;
            res.send_kind = SK_ACK;
            res.ack_block = last_q;
          end
        end
      end
      KIND_PACKET: begin
        unique case (phase_q)
          PH_WAIT: begin
            // First answer from the server: OACK, DATA 1 or ERROR.
            if (len_ok) begin
              if (item_i.opcode == OP_ERROR) begin
                phase_d    = PH_IDLE;
                wcnt_d     = 7'd0;
                retry_d    = 4'd0;
                res.status = ST_FAIL;
              end else if (item_i.opcode == OP_OACK) begin
                if (!item_i.oack_valid) begin
                  phase_d       = PH_IDLE;
                  wcnt_d        = 7'd0;
                  retry_d       = 4'd0;
                  res.send_kind = SK_ILL;
                  res.status    = ST_FAIL;
                end else begin
                  wlim_d        = win_clamp;
                  exp_d         = 16'd1;
                  last_d        = 16'd0;
                  wcnt_d        = 7'd0;
                  retry_d       = 4'd0;
                  phase_d       = PH_RECV;
                  res.send_kind = SK_ACK;
                end
              end else if (item_i.opcode == OP_DATA && item_i.block_num == 16'd1) begin
                res.send_kind     = SK_ACK;
                res.ack_block     = 16'd1;
                res.write_payload = 1'b1;
                wcnt_d            = 7'd0;
                retry_d           = 4'd0;
                if (short_pay) begin
                  phase_d    = PH_IDLE;
                  res.status = ST_DONE;
                end else begin
                  exp_d   = 16'd2;
                  last_d  = 16'd1;
                  phase_d = PH_RECV;
                end
              end
            end
          end
          PH_RECV: begin
            // Any packet from anywhere proves the link is alive.
            retry_d = 4'd0;
            if (len_ok) begin
              if (!item_i.sender_matches) begin
                res.send_kind = SK_TID;
              end else if (item_i.opcode == OP_ERROR) begin
                phase_d    = PH_IDLE;
                wcnt_d     = 7'd0;
                res.status = ST_FAIL;
              end else if (item_i.opcode == OP_DATA) begin
                if (item_i.block_num == exp_q) begin
                  last_d            = item_i.block_num;
                  exp_d             = exp_q + 16'd1;
                  res.write_payload = 1'b1;
                  if (short_pay) begin
                    phase_d       = PH_IDLE;
                    wcnt_d        = 7'd0;
                    res.send_kind = SK_ACK;
                    res.ack_block = item_i.block_num;
                    res.status    = ST_DONE;
                  end else if (wcnt_inc >= wlim_q) begin
                    wcnt_d        = 7'd0;
                    res.send_kind = SK_ACK;
                    res.ack_block = item_i.block_num;
                  end else begin
                    wcnt_d = wcnt_inc;
                  end
                end else if (item_i.block_num == exp_q - 16'd1) begin
                  // Duplicate of the previous block: the ACK was lost.
                  res.send_kind = SK_ACK;
                  res.ack_block = last_q;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Transfer state, updated once per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      exp_q   <= 16'd0;
      last_q  <= 16'd0;
      wcnt_q  <= 7'd0;
      retry_q <= 4'd0;
      wlim_q  <= 7'd1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      last_q  <= last_d;
      wcnt_q  <= wcnt_d;
      retry_q <= retry_d;
      wlim_q  <= wlim_d;
    end
  end

  assign result_o = res;

endmodule

// File: src/tftp_windowed_receiver_core.sv
// TFTP windowed read receiver. One result transaction follows each event
// transaction; the block takes one event per clock cycle while the result side
// is not stalled, and a result is presented from the result register after its
// event has passed through the input register. The transfer-state registers in
// the engine are updated once per event. Depends on tftprx_pkg, tftprx_in_stage
// and tftprx_engine.
module tftp_windowed_receiver_core #(
  parameter int unsigned MAX_RETRIES = 5,
  parameter int unsigned BLOCK_BYTES = 512,
  parameter int unsigned MAX_WINDOW  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [9:0]  pkt_len_i,
  input  logic [15:0] opcode_i,
  input  logic [15:0] block_num_i,
  input  logic        sender_matches_i,
  input  logic        oack_valid_i,
  input  logic [6:0]  oack_window_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  send_kind_o,
  output logic [15:0] ack_block_o,
  output logic        write_payload_o,
  output logic [1:0]  status_o
);
  import tftprx_pkg::*;

  item_t   in_item;
  item_t   cur_item;
  logic    cur_valid;
  logic    fire;
  result_t step_res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign in_item = '{
    kind:           kind_i,
    pkt_len:        pkt_len_i,
    opcode:         opcode_i,
    block_num:      block_num_i,
    sender_matches: sender_matches_i,
    oack_valid:     oack_valid_i,
    oack_window:    oack_window_i
  };

  // An event is processed when the result register is free or being drained.
  assign fire = cur_valid && (!out_valid_q || out_ready_i);

  tftprx_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (fire),
    .valid_o    (cur_valid),
    .item_o     (cur_item)
  );

  tftprx_engine #(
    .MAX_RETRIES (MAX_RETRIES),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (cur_item),
    .result_o (step_res)
  );

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_kind_o     = res_q.send_kind;
  assign ack_block_o     = res_q.ack_block;
  assign write_payload_o = res_q.write_payload;
  assign status_o        = res_q.status;

endmodule

// File: src/tftprx_checker.sv
// Port-level checks for the TFTP windowed receiver, bound to its top level.
// Depends on tftprx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tftprx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  send_kind_o,
  input logic [15:0] ack_block_o,
  input logic        write_payload_o,
  input logic [1:0]  status_o
);
  import tftprx_pkg::*;

  // A stalled result transaction keeps its valid and payload.
  `TFTPRX_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(send_kind_o) && $stable(ack_block_o) && $stable(status_o)), "result changed while stalled")

  // Only an ACK carries a block number.
  `TFTPRX_NEVER(a_ack_only, clk_i, rst_ni, out_valid_o && send_kind_o != SK_ACK && ack_block_o != 16'd0, "block number without ACK")

  // A written payload is always acknowledged or silently windowed, never failed.
  `TFTPRX_NEVER(a_write_ok, clk_i, rst_ni, out_valid_o && write_payload_o && (status_o == ST_FAIL || (send_kind_o != SK_ACK && send_kind_o != SK_NONE)), "payload written with bad reply")

  // A failure sends nothing or an illegal-op error.
  `TFTPRX_NEVER(a_fail_reply, clk_i, rst_ni, out_valid_o && status_o == ST_FAIL && send_kind_o != SK_NONE && send_kind_o != SK_ILL, "failure with unexpected reply")

  // The input side only stalls while a result transaction is held back.
  `TFTPRX_NEVER(a_stall_cause, clk_i, rst_ni, !in_ready_o && !(out_valid_o && !out_ready_i), "input stalled with result side free")

endmodule

bind tftp_windowed_receiver_core tftprx_checker u_tftprx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .send_kind_o     (send_kind_o),
  .ack_block_o     (ack_block_o),
  .write_payload_o (write_payload_o),
  .status_o        (status_o)
);
